[hdl/tiny_language_lexer_assert.svh]
// ----------------------------------------------------------------------------
// tiny_language_lexer_assert.svh
// assertion macros shared by the lexer rtl
// ----------------------------------------------------------------------------
`ifndef TINY_LANGUAGE_LEXER_ASSERT_SVH
`define TINY_LANGUAGE_LEXER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked property, held off while reset is asserted
`define TLL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

// checked property, also watched during reset
`define TLL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: property failed");

`else

`define TLL_ASSERT(lbl, clk, rst_n, prop)
`define TLL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hdl/tll_pkg.sv]
// ----------------------------------------------------------------------------
// tll_pkg
// types, codes and keyword table for the tiny language lexer
// ----------------------------------------------------------------------------
package tll_pkg;

    localparam int MAX_IDENT_CHARS = 8;
    localparam int NUM_KW          = 13;
    localparam int FIFO_DEPTH      = 4;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NUMBER  = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_LT      = 3'd3,
        MODE_GT      = 3'd4,
        MODE_COLON   = 3'd5,
        MODE_DISCARD = 3'd6
    } t_mode;

    // token kinds
    localparam logic [4:0] K_NUMBER  = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_EOF     = 5'd2;
    localparam logic [4:0] K_PLUS    = 5'd3;
    localparam logic [4:0] K_MINUS   = 5'd4;
    localparam logic [4:0] K_MUL     = 5'd5;
    localparam logic [4:0] K_DIV     = 5'd6;
    localparam logic [4:0] K_EQ      = 5'd7;
    localparam logic [4:0] K_LE      = 5'd8;
    localparam logic [4:0] K_NE      = 5'd9;
    localparam logic [4:0] K_LT      = 5'd10;
    localparam logic [4:0] K_GE      = 5'd11;
    localparam logic [4:0] K_GT      = 5'd12;
    localparam logic [4:0] K_LPAREN  = 5'd13;
    localparam logic [4:0] K_RPAREN  = 5'd14;
    localparam logic [4:0] K_ASSIGN  = 5'd15;
    localparam logic [4:0] K_SEMI    = 5'd16;
    localparam logic [4:0] K_COMMA   = 5'd17;
    localparam logic [4:0] K_KW_BASE = 5'd18;
    localparam logic [4:0] K_ERROR   = 5'd31;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_INVALID  = 3'd1;
    localparam logic [2:0] ERR_COLON    = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW = 3'd3;
    localparam logic [2:0] ERR_LONG     = 3'd4;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // one output token
    typedef struct packed {
        logic [4:0]  kind;
        logic [62:0] number_value;
        logic [63:0] ident_chars;
        logic [3:0]  ident_length;
        logic [2:0]  error_code;
        logic        last;
    } t_token;

    // reorder a right-justified string so the first character sits in bits 7:0
    function automatic logic [63:0] kw_pack(input logic [63:0] text, input logic [3:0] len);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                v[8*i +: 8] = text[8*(int'(len) - 1 - i) +: 8];
            end
        end
        return v;
    endfunction

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd5, 4'd3, 4'd8, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd5, 4'd7, 4'd3
    };

    localparam logic [63:0] KW_PACKED [NUM_KW] = '{
        kw_pack("const", 4'd5),    kw_pack("var", 4'd3),
        kw_pack("function", 4'd8), kw_pack("begin", 4'd5),
        kw_pack("end", 4'd3),      kw_pack("if", 4'd2),
        kw_pack("then", 4'd4),     kw_pack("while", 4'd5),
        kw_pack("do", 4'd2),       kw_pack("return", 4'd6),
        kw_pack("write", 4'd5),    kw_pack("writeln", 4'd7),
        kw_pack("odd", 4'd3)
    };

    // keyword kind for a packed identifier, ident kind when none matches
    function automatic logic [4:0] kw_lookup(input logic [63:0] chars, input logic [3:0] len);
        logic [4:0] kind;
        kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (chars == KW_PACKED[k] && len == KW_LEN[k]) begin
                kind = K_KW_BASE + 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_start(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

[hdl/tiny_language_lexer.sv]
// ----------------------------------------------------------------------------
// tiny_language_lexer
// streaming lexer: one source byte in, zero to two tokens out per byte
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  source    in         i_valid / o_stall     i_ch
//  token     out        o_valid / i_stall     o_kind .. o_last
//
//  one source byte is taken per cycle while o_stall is low; its tokens are
//  formed in that cycle and land in a 4-entry queue read by the output port.
//  a byte that ends one token and emits another adds one extra output beat.
//  o_stall rises while 3 or more tokens are queued (room for two is needed).
//  synchronous active-low reset clears the scanner mode and the queue.
// ----------------------------------------------------------------------------
`include "tiny_language_lexer_assert.svh"

module tiny_language_lexer
    import tll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_kind,
    output logic [62:0] o_number_value,
    output logic [63:0] o_ident_chars,
    output logic [3:0]  o_ident_length,
    output logic [2:0]  o_error_code,
    output logic        o_last
);

    // scanner state
    t_mode       r_mode, n_mode;
    logic [62:0] r_acc, n_acc;
    logic        r_ovf, n_ovf;
    logic [63:0] r_buf, n_buf;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_long, n_long;

    // token queue
    t_token      r_fifo [FIFO_DEPTH];
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_count;

    t_token      tok_a, tok_b, slot0;
    logic        va, vb, done;
    logic [1:0]  push_n;
    logic        accept, pop;
    logic [66:0] mul10;
    logic        mul_ovf;

    assign accept = i_valid && !o_stall;
    assign o_valid = (r_count != 3'd0);
    assign pop = o_valid && !i_stall;
    assign o_stall = (r_count >= 3'(FIFO_DEPTH - 1));

    // accum * 10 + digit, with overflow past 63 bits
    assign mul10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {63'b0, i_ch[3:0]};
    assign mul_ovf = |mul10[66:63];

    // scanner step: token a ends a pending token, token b comes from this byte
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_ovf  = r_ovf;
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        n_long = r_long;
        tok_a  = '0;
        tok_b  = '0;
        va     = 1'b0;
        vb     = 1'b0;
        done   = 1'b0;

        unique case (r_mode)
            MODE_NUMBER: begin
                if (is_digit(i_ch)) begin
                    if (!r_ovf) begin
                        if (mul_ovf) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = mul10[62:0];
                        end
                    end
                    done = 1'b1;
                end else begin
                    va = 1'b1;
                    if (r_ovf) begin
                        tok_a.kind       = K_ERROR;
                        tok_a.error_code = ERR_OVERFLOW;
                        n_mode           = MODE_DISCARD;
                    end else begin
                        tok_a.kind         = K_NUMBER;
                        tok_a.number_value = r_acc;
                        n_mode             = MODE_IDLE;
                    end
                    n_acc = '0;
                    n_ovf = 1'b0;
                end
            end
            MODE_IDENT: begin
                if (is_start(i_ch) || is_digit(i_ch)) begin
                    if (r_cnt < 4'(MAX_IDENT_CHARS)) begin
                        n_buf = r_buf | ({56'b0, i_ch} << {r_cnt[2:0], 3'b000});
                        n_cnt = r_cnt + 4'd1;
                    end else begin
                        n_long = 1'b1;
                    end
                    done = 1'b1;
                end else begin
                    va = 1'b1;
                    if (r_long) begin
                        tok_a.kind       = K_ERROR;
                        tok_a.error_code = ERR_LONG;
                        n_mode           = MODE_DISCARD;
                    end else begin
                        tok_a.kind = kw_lookup(r_buf, r_cnt);
                        if (tok_a.kind == K_IDENT) begin
                            tok_a.ident_chars  = r_buf;
                            tok_a.ident_length = r_cnt;
                        end
                        n_mode = MODE_IDLE;
                    end
                    n_buf  = '0;
                    n_cnt  = '0;
                    n_long = 1'b0;
                end
            end
            MODE_LT: begin
                n_mode = MODE_IDLE;
                va     = 1'b1;
                if (i_ch == CH_EQ) begin
                    tok_a.kind = K_LE;
                    done       = 1'b1;
                end else if (i_ch == CH_GT) begin
                    tok_a.kind = K_NE;
                    done       = 1'b1;
                end else begin
                    tok_a.kind = K_LT;
                end
            end
            MODE_GT: begin
                n_mode = MODE_IDLE;
                va     = 1'b1;
                if (i_ch == CH_EQ) begin
                    tok_a.kind = K_GE;
                    done       = 1'b1;
                end else begin
                    tok_a.kind = K_GT;
                end
            end
            MODE_COLON: begin
                va = 1'b1;
                if (i_ch == CH_EQ) begin
                    tok_a.kind = K_ASSIGN;
                    n_mode     = MODE_IDLE;
                    done       = 1'b1;
                end else begin
                    tok_a.kind       = K_ERROR;
                    tok_a.error_code = ERR_COLON;
                    n_mode           = MODE_DISCARD;
                end
            end
            MODE_IDLE: begin
            end
            MODE_DISCARD: begin
            end
            default: begin
                n_mode = MODE_DISCARD;
            end
        endcase

        // byte not consumed above: discard, skip a blank, or start a new token
        if (!done) begin
            if (n_mode == MODE_DISCARD) begin
                if (i_ch == CH_NUL) begin
                    vb         = 1'b1;
                    tok_b.kind = K_EOF;
                    n_mode     = MODE_IDLE;
                end
            end else if (is_blank(i_ch)) begin
            end else if (i_ch == CH_NUL) begin
                vb         = 1'b1;
                tok_b.kind = K_EOF;
            end else if (is_digit(i_ch)) begin
                n_acc  = {59'b0, i_ch[3:0]};
                n_ovf  = 1'b0;
                n_mode = MODE_NUMBER;
            end else if (is_start(i_ch)) begin
                n_buf  = {56'b0, i_ch};
                n_cnt  = 4'd1;
                n_long = 1'b0;
                n_mode = MODE_IDENT;
            end else begin
                unique case (i_ch)
                    CH_PLUS:   begin vb = 1'b1; tok_b.kind = K_PLUS;   end
                    CH_MINUS:  begin vb = 1'b1; tok_b.kind = K_MINUS;  end
                    CH_STAR:   begin vb = 1'b1; tok_b.kind = K_MUL;    end
                    CH_SLASH:  begin vb = 1'b1; tok_b.kind = K_DIV;    end
                    CH_EQ:     begin vb = 1'b1; tok_b.kind = K_EQ;     end
                    CH_LPAREN: begin vb = 1'b1; tok_b.kind = K_LPAREN; end
                    CH_RPAREN: begin vb = 1'b1; tok_b.kind = K_RPAREN; end
                    CH_SEMI:   begin vb = 1'b1; tok_b.kind = K_SEMI;   end
                    CH_COMMA:  begin vb = 1'b1; tok_b.kind = K_COMMA;  end
                    CH_LT:     begin n_mode = MODE_LT;    end
                    CH_GT:     begin n_mode = MODE_GT;    end
                    CH_COLON:  begin n_mode = MODE_COLON; end
                    default: begin
                        vb               = 1'b1;
                        tok_b.kind       = K_ERROR;
                        tok_b.error_code = ERR_INVALID;
                        n_mode           = MODE_DISCARD;
                    end
                endcase
            end
        end

        // mark the final token of this byte
        if (vb) begin
            tok_b.last = 1'b1;
        end else begin
            tok_a.last = 1'b1;
        end
    end

    assign slot0  = va ? tok_a : tok_b;
    assign push_n = {1'b0, va} + {1'b0, vb};

    // scanner state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
            r_buf  <= '0;
            r_cnt  <= '0;
            r_long <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_long <= n_long;
        end
    end

    // token queue storage
    always_ff @(posedge i_clk) begin
        if (accept && push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= slot0;
        end
        if (accept && push_n == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= tok_b;
        end
    end

    // token queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + push_n;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (accept ? {1'b0, push_n} : 3'd0) - {2'b0, pop};
        end
    end

    // output beat from the queue head
    assign o_kind         = r_fifo[r_rd_ptr].kind;
    assign o_number_value = r_fifo[r_rd_ptr].number_value;
    assign o_ident_chars  = r_fifo[r_rd_ptr].ident_chars;
    assign o_ident_length = r_fifo[r_rd_ptr].ident_length;
    assign o_error_code   = r_fifo[r_rd_ptr].error_code;
    assign o_last         = r_fifo[r_rd_ptr].last;

    // checks
    `TLL_ASSERT(a_fifo_bound, i_clk, i_rst_n, r_count <= 3'(FIFO_DEPTH))
    `TLL_ASSERT(a_num_zero, i_clk, i_rst_n, (o_valid && o_kind != K_NUMBER) |-> (o_number_value == '0))
    `TLL_ASSERT(a_err_code, i_clk, i_rst_n, (o_valid && o_kind == K_ERROR) |-> (o_error_code != ERR_NONE))
    `TLL_ASSERT(a_ident_len, i_clk, i_rst_n, (o_valid && o_kind == K_IDENT) |-> ((o_ident_length != 4'd0) && (o_ident_length <= 4'(MAX_IDENT_CHARS))))
    `TLL_ASSERT(a_eof_last, i_clk, i_rst_n, (o_valid && o_kind == K_EOF) |-> o_last)

endmodule
